// ----- rtl/losp_pkg.sv -----
package losp_pkg;

    localparam int COORD_W = 16;
    localparam int LEN_W   = 32;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_LOAD   = 2'd1;
    localparam logic [1:0] OP_POINT  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]                op;
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
        logic                      last_point;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] kept_x;
        logic signed [COORD_W-1:0] kept_y;
        logic [LEN_W-1:0]          total_length;
        logic                      path_end;
        logic                      table_overflow;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic take_item;    // capture input item
        logic do_clear;
        logic do_load;
        logic start_point;  // first point of a path
        logic scan_start;   // reset scan index
        logic scan_step;    // issue next segment read / test
        logic len_prev;     // start root of anchor->previous
        logic len_cur;      // start root of anchor->current
        logic move_anchor;
        logic set_prev;
        logic emit_anchor;
        logic emit_final;
        logic end_path;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_load;
        logic is_clear;
        logic is_point;
        logic is_last;
        logic started;
        logic scan_done;
        logic hit;
        logic root_busy;
        logic out_busy;
    } ctrl_sts_t;

endpackage

// ----- rtl/losp_ctrl.sv -----
module losp_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  losp_pkg::ctrl_sts_t  sts,
    output losp_pkg::ctrl_cmd_t  cmd
);
    import losp_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DEC   = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_HIT   = 3'd3;
    localparam logic [2:0] ST_HITW  = 3'd4;
    localparam logic [2:0] ST_LAST  = 3'd5;
    localparam logic [2:0] ST_LASTW = 3'd6;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.take_item = 1'b1;
                    state_next    = ST_DEC;
                end
            end
            ST_DEC: begin
                if (sts.is_clear) begin
                    cmd.do_clear = 1'b1;
                    state_next   = ST_IDLE;
                end else if (sts.is_load) begin
                    cmd.do_load = 1'b1;
                    state_next  = ST_IDLE;
                end else if (!sts.is_point) begin
                    state_next = ST_IDLE;
                end else if (!sts.started) begin
                    if (!sts.out_busy) begin
                        cmd.start_point = 1'b1;
                        state_next = sts.is_last ? ST_LAST : ST_IDLE;
                    end
                end else begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (sts.hit) begin
                    state_next = ST_HIT;
                end else if (sts.scan_done) begin
                    cmd.set_prev = 1'b1;
                    state_next   = sts.is_last ? ST_LAST : ST_IDLE;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_HIT: begin
                if (!sts.root_busy) begin
                    cmd.len_prev = 1'b1;
                    state_next   = ST_HITW;
                end
            end
            ST_HITW: begin
                if (!sts.root_busy && !sts.out_busy) begin
                    cmd.move_anchor = 1'b1;
                    cmd.emit_anchor = 1'b1;
                    cmd.set_prev    = 1'b1;
                    state_next      = sts.is_last ? ST_LAST : ST_IDLE;
                end
            end
            ST_LAST: begin
                if (!sts.root_busy) begin
                    cmd.len_cur = 1'b1;
                    state_next  = ST_LASTW;
                end
            end
            ST_LASTW: begin
                if (!sts.root_busy && !sts.out_busy) begin
                    cmd.emit_final = 1'b1;
                    cmd.end_path   = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ----- rtl/losp_dp.sv -----
module losp_dp #(
    parameter int MAX_SEGMENTS     = 64,
    parameter int LENGTH_FRAC_BITS = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  losp_pkg::in_item_t  s_item,
    input  losp_pkg::ctrl_cmd_t cmd,
    output losp_pkg::ctrl_sts_t sts,
    output logic                m_valid,
    input  logic                m_ready,
    output losp_pkg::out_item_t m_item
);
    import losp_pkg::*;

    localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
    localparam int C     = COORD_W;
    localparam int DW    = C + 1;
    localparam int PW    = 2 * DW + 1;
    localparam int SQ_IN = 2 * DW + 1;
    localparam int RBITS = (SQ_IN + 1) / 2 + LENGTH_FRAC_BITS;
    localparam int RCW   = $clog2(RBITS + 1);
    localparam int RW    = RBITS + 2;

    typedef struct packed {
        logic signed [C-1:0] x0;
        logic signed [C-1:0] y0;
        logic signed [C-1:0] x1;
        logic signed [C-1:0] y1;
    } seg_t;

    seg_t seg_mem [MAX_SEGMENTS];
    seg_t rd_reg;

    logic [CNT_W-1:0]  count_reg;
    logic              ovf_reg, started_reg;
    logic [1:0]        op_reg;
    logic signed [C-1:0] cx_reg, cy_reg, bx_reg, by_reg;
    logic              last_reg;
    logic signed [C-1:0] ax_reg, ay_reg, px_reg, py_reg;
    logic [LEN_W-1:0]  sum_reg;

    always_ff @(posedge aclk) begin
        if (cmd.take_item) begin
            op_reg   <= s_item.op;
            cx_reg   <= C'(s_item.ax);
            cy_reg   <= C'(s_item.ay);
            bx_reg   <= C'(s_item.bx);
            by_reg   <= C'(s_item.by);
            last_reg <= s_item.last_point;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.do_load && count_reg < CNT_W'(MAX_SEGMENTS))
            seg_mem[count_reg[IDX_W-1:0]] <= '{cx_reg, cy_reg, bx_reg, by_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else if (cmd.do_clear) begin
            count_reg <= '0;
        end else if (cmd.do_load) begin
            if (count_reg < CNT_W'(MAX_SEGMENTS)) count_reg <= count_reg + 1'b1;
            else                                  ovf_reg   <= 1'b1;
        end
    end

    // scan: read (stage 0), products (stage 1), compare (stage 2)
    logic [CNT_W-1:0] idx_reg;
    logic             v0_reg, v1_reg, hit_reg;
    logic signed [DW-1:0] s1x, s1y;
    logic signed [DW-1:0] s2x_w, s2y_w, ox_w, oy_w;
    logic signed [PW-1:0] m1_reg, m2_reg, m3_reg, m4_reg, m5_reg, m6_reg;
    logic signed [PW:0]   d_w, ns_w, nt_w, da, nsa, nta;

    assign s1x   = DW'(cx_reg) - DW'(ax_reg);
    assign s1y   = DW'(cy_reg) - DW'(ay_reg);
    assign s2x_w = DW'(rd_reg.x1) - DW'(rd_reg.x0);
    assign s2y_w = DW'(rd_reg.y1) - DW'(rd_reg.y0);
    assign ox_w  = DW'(ax_reg) - DW'(rd_reg.x0);
    assign oy_w  = DW'(ay_reg) - DW'(rd_reg.y0);

    always_ff @(posedge aclk) begin
        if (idx_reg < count_reg) rd_reg <= seg_mem[idx_reg[IDX_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        m1_reg <= PW'(s1x * s2y_w);
        m2_reg <= PW'(s2x_w * s1y);
        m3_reg <= PW'(s1x * oy_w);
        m4_reg <= PW'(s1y * ox_w);
        m5_reg <= PW'(s2x_w * oy_w);
        m6_reg <= PW'(s2y_w * ox_w);
    end

    assign d_w  = (PW+1)'(m1_reg) - (PW+1)'(m2_reg);
    assign ns_w = (PW+1)'(m3_reg) - (PW+1)'(m4_reg);
    assign nt_w = (PW+1)'(m5_reg) - (PW+1)'(m6_reg);
    assign da   = d_w[PW] ? -d_w  : d_w;
    assign nsa  = d_w[PW] ? -ns_w : ns_w;
    assign nta  = d_w[PW] ? -nt_w : nt_w;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
            v0_reg  <= 1'b0;
            v1_reg  <= 1'b0;
            hit_reg <= 1'b0;
        end else if (cmd.scan_start) begin
            idx_reg <= '0;
            v0_reg  <= 1'b0;
            v1_reg  <= 1'b0;
            hit_reg <= 1'b0;
        end else if (cmd.scan_step) begin
            v0_reg <= idx_reg < count_reg;
            if (idx_reg < count_reg) idx_reg <= idx_reg + 1'b1;
            v1_reg <= v0_reg;
            if (v1_reg && d_w != '0 && nsa >= 0 && nsa <= da && nta > 0 && nta < da)
                hit_reg <= 1'b1;
        end
    end

    // integer square root, one result bit per cycle
    logic            r_busy_reg;
    logic [RCW-1:0]  r_cnt_reg;
    logic [2*RBITS-1:0] r_val_reg;
    logic [RW-1:0]   r_rem_reg, r_trial, r_remsh;
    logic [RBITS-1:0] r_root_reg;
    logic signed [DW-1:0] ldx, ldy;
    logic signed [C-1:0]  lx, ly;
    logic [2*DW-1:0] sq_x_reg, sq_y_reg;
    logic            sq_v_reg;
    logic [LEN_W:0]  sum_w;

    assign lx  = cmd.len_prev ? px_reg : cx_reg;
    assign ly  = cmd.len_prev ? py_reg : cy_reg;
    assign ldx = DW'(lx) - DW'(ax_reg);
    assign ldy = DW'(ly) - DW'(ay_reg);
    assign r_remsh = {r_rem_reg[RW-3:0], r_val_reg[2*RBITS-1 -: 2]};
    assign r_trial = {r_root_reg, 2'b01};
    assign sum_w   = (LEN_W+1)'(sum_reg) + (LEN_W+1)'(r_root_reg);

    always_ff @(posedge aclk) begin
        if (cmd.len_prev || cmd.len_cur) begin
            sq_x_reg <= (2*DW)'(ldx * ldx);
            sq_y_reg <= (2*DW)'(ldy * ldy);
        end
        if (sq_v_reg) begin
            r_val_reg  <= (2*RBITS)'({(2*RBITS)'(sq_x_reg) + (2*RBITS)'(sq_y_reg)}
                          << (2 * LENGTH_FRAC_BITS));
            r_rem_reg  <= '0;
            r_root_reg <= '0;
        end else if (r_busy_reg) begin
            r_val_reg <= r_val_reg << 2;
            if (r_remsh >= r_trial) begin
                r_rem_reg  <= r_remsh - r_trial;
                r_root_reg <= {r_root_reg[RBITS-2:0], 1'b1};
            end else begin
                r_rem_reg  <= r_remsh;
                r_root_reg <= {r_root_reg[RBITS-2:0], 1'b0};
            end
        end
    end

    logic r_done;
    assign r_done = r_busy_reg && r_cnt_reg == RCW'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_v_reg   <= 1'b0;
            r_busy_reg <= 1'b0;
            r_cnt_reg  <= '0;
        end else begin
            sq_v_reg <= cmd.len_prev || cmd.len_cur;
            if (sq_v_reg) begin
                r_busy_reg <= 1'b1;
                r_cnt_reg  <= RCW'(RBITS);
            end else if (r_busy_reg) begin
                r_cnt_reg <= r_cnt_reg - 1'b1;
                if (r_cnt_reg == RCW'(1)) r_busy_reg <= 1'b0;
            end
        end
    end

    logic add_pend_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) add_pend_reg <= 1'b0;
        else          add_pend_reg <= r_done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg <= 1'b0;
            sum_reg     <= '0;
            ax_reg      <= '0;
            ay_reg      <= '0;
            px_reg      <= '0;
            py_reg      <= '0;
        end else begin
            if (cmd.start_point) begin
                started_reg <= 1'b1;
                sum_reg     <= '0;
                ax_reg      <= cx_reg;
                ay_reg      <= cy_reg;
                px_reg      <= cx_reg;
                py_reg      <= cy_reg;
            end
            if (add_pend_reg)
                sum_reg <= sum_w[LEN_W] ? '1 : sum_w[LEN_W-1:0];
            if (cmd.move_anchor) begin
                ax_reg <= px_reg;
                ay_reg <= py_reg;
            end
            if (cmd.set_prev) begin
                px_reg <= cx_reg;
                py_reg <= cy_reg;
            end
            if (cmd.end_path) started_reg <= 1'b0;
        end
    end

    logic emit;
    assign emit = cmd.start_point || cmd.emit_anchor || cmd.emit_final;

    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid <= 1'b0;
        else if (emit) m_valid <= 1'b1;
        else if (m_ready) m_valid <= 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_item.kept_x         <= cmd.emit_anchor ? px_reg : cx_reg;
            m_item.kept_y         <= cmd.emit_anchor ? py_reg : cy_reg;
            m_item.total_length   <= cmd.emit_final ? sum_reg : '0;
            m_item.path_end       <= cmd.emit_final;
            m_item.table_overflow <= ovf_reg;
        end
    end

    assign sts.is_load   = op_reg == OP_LOAD;
    assign sts.is_clear  = op_reg == OP_CLEAR;
    assign sts.is_point  = op_reg == OP_POINT;
    assign sts.is_last   = last_reg;
    assign sts.started   = started_reg;
    assign sts.scan_done = !v0_reg && !v1_reg && idx_reg >= count_reg;
    assign sts.hit       = hit_reg;
    assign sts.root_busy = sq_v_reg || r_busy_reg || add_pend_reg;
    assign sts.out_busy  = m_valid && !m_ready;

endmodule

// ----- rtl/line_of_sight_path_pruner.sv -----
// Line-of-sight path pruner. Op 0 clears the obstacle table, op 1 appends a
// segment (dropped, with a sticky overflow flag, when full), op 2 streams path
// points. A path point other than the first is decoded and then scans every
// stored segment through a three-stage read/multiply/compare pipe, stopping
// after the first hit. Each length added (on a hit, and for the final point)
// runs a bit-serial square root of 18 + LENGTH_FRAC_BITS steps before the sum
// is updated. Results leave through a registered output; a stalled result
// holds back the next result until it is taken.
module line_of_sight_path_pruner #(
    parameter int MAX_SEGMENTS     = 64,
    parameter int LENGTH_FRAC_BITS = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  losp_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output losp_pkg::out_item_t m_data
);
    import losp_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    losp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    losp_dp #(
        .MAX_SEGMENTS     (MAX_SEGMENTS),
        .LENGTH_FRAC_BITS (LENGTH_FRAC_BITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_data)
    );

endmodule

// ----- rtl/losp_checker.sv -----
module losp_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input losp_pkg::out_item_t m_data,
    input logic                m_valid,
    input logic                m_ready
);
    import losp_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result dropped or changed while stalled");

    a_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.path_end |-> m_data.total_length == '0)
        else $error("length on a non-final point");

    a_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready ##1 m_valid && $past(m_data.table_overflow)
        |-> m_data.table_overflow)
        else $error("overflow flag not sticky");

    a_rdy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("accepted two items back to back");

endmodule

bind line_of_sight_path_pruner losp_checker u_chk (.*);
